### design/hpp_pkg.sv
// Shared types and constants for the hexagonal prism point classifier.
// Holds the pipeline stage records, the register map and the face numbering.
// No dependencies.
package hpp_pkg;

    localparam int COORD_W  = 32;   // signed Q16.16 coordinate
    localparam int REG_W    = 31;   // unsigned Q15.16 register value
    localparam int APB_AW   = 4;    // three word registers
    localparam int APB_DW   = 32;
    localparam int MASK_W   = 8;
    localparam int FACE_W   = 4;
    localparam int NUM_FACES = 8;
    localparam int LEN_W    = 34;   // doubled lengths, signed
    localparam int MAG_W    = 33;   // doubled lengths once known non-negative
    localparam int AXSQ_W   = 2 * COORD_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int CMP_W    = SQ_W + 2;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SKIN   = 2'd2
    } t_reg_idx;

    localparam logic [REG_W-1:0] SKIN_RESET = REG_W'(66);

    // Face numbering, shared by the face mask and the face code.
    localparam int SIDE_BACK        = 0;
    localparam int SIDE_BACK_LEFT   = 1;
    localparam int SIDE_BACK_RIGHT  = 2;
    localparam int SIDE_FRONT       = 3;
    localparam int SIDE_FRONT_LEFT  = 4;
    localparam int SIDE_FRONT_RIGHT = 5;
    localparam int CAP_BOTTOM       = 6;
    localparam int CAP_TOP          = 7;
    localparam logic [FACE_W-1:0] FACE_NONE = FACE_W'(8);

    typedef struct packed {
        logic [REG_W-1:0] radius;
        logic [REG_W-1:0] height;
        logic [REG_W-1:0] skin;
    } t_cfg;

    // Sign information used to pick the lateral sector.
    typedef struct packed {
        logic x_pos;
        logic x_neg;
        logic y_pos;
        logic y_neg;
        logic origin;
    } t_sect;

    // Results of the tests along the prism axis.
    typedef struct packed {
        logic in_z;
        logic out_z;
        logic hit_bottom;
        logic hit_top;
    } t_ztest;

    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [LEN_W-1:0]   a_in;    // 2*radius - skin, signed
        logic [LEN_W-1:0]   a_out;   // 2*radius + skin
        t_ztest             zt;
        t_sect              sect;
        logic [MASK_W-1:0]  mask;
    } t_s1;

    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [MAG_W-1:0]   a_in;
        logic [MAG_W-1:0]   b_in;
        logic [MAG_W-1:0]   a_out;
        logic [MAG_W-1:0]   b_out;
        logic               in_ok;   // shrunk hexagon spans are non-negative
        logic               out_ok;
        t_ztest             zt;
        t_sect              sect;
        logic [MASK_W-1:0]  mask;
    } t_s2;

    typedef struct packed {
        logic [AXSQ_W-1:0]  ax_sq;
        logic [AXSQ_W-1:0]  ay_sq;
        logic [SQ_W-1:0]    a_in_sq;
        logic [SQ_W-1:0]    b_in_sq;
        logic [SQ_W-1:0]    a_out_sq;
        logic [SQ_W-1:0]    b_out_sq;
        logic               in_ok;
        logic               out_ok;
        t_ztest             zt;
        t_sect              sect;
        logic [MASK_W-1:0]  mask;
    } t_s3;

endpackage

### design/hpp_if.sv
// Valid/ready channel interfaces for points in and classifications out.
// Depends on hpp_pkg for field widths.
interface hpp_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [hpp_pkg::COORD_W-1:0]    pos_x;
    logic signed [hpp_pkg::COORD_W-1:0]    pos_y;
    logic signed [hpp_pkg::COORD_W-1:0]    pos_z;
    logic        [hpp_pkg::MASK_W-1:0]     face_mask;

    modport source (output valid, pos_x, pos_y, pos_z, face_mask, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, face_mask, output ready);
endinterface

interface hpp_out_if;
    logic                               valid;
    logic                               ready;
    logic                               inside_res;
    logic                               outside;
    logic                               on_surface;
    logic [hpp_pkg::FACE_W-1:0]         normal_face;

    modport source (output valid, inside_res, outside, on_surface, normal_face,
                    input ready);
    modport sink   (input valid, inside_res, outside, on_surface, normal_face,
                    output ready);
endinterface

### design/hpp_apb_regs.sv
// APB-style register block holding radius, height and skin.
// Depends on hpp_pkg for the register map and the configuration record.
module hpp_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpp_pkg::APB_AW-1:0]    paddr,
    input  logic [hpp_pkg::APB_DW-1:0]    pwdata,
    output logic [hpp_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output hpp_pkg::t_cfg                 o_cfg
);

    hpp_pkg::t_cfg r_cfg;
    hpp_pkg::t_cfg n_cfg;
    hpp_pkg::t_reg_idx idx;
    logic wr;

    assign idx    = hpp_pkg::t_reg_idx'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (idx)
                hpp_pkg::REG_RADIUS: n_cfg.radius = pwdata[hpp_pkg::REG_W-1:0];
                hpp_pkg::REG_HEIGHT: n_cfg.height = pwdata[hpp_pkg::REG_W-1:0];
                hpp_pkg::REG_SKIN:   n_cfg.skin   = pwdata[hpp_pkg::REG_W-1:0];
                default:             n_cfg        = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            hpp_pkg::REG_RADIUS: prdata = {1'b0, r_cfg.radius};
            hpp_pkg::REG_HEIGHT: prdata = {1'b0, r_cfg.height};
            hpp_pkg::REG_SKIN:   prdata = {1'b0, r_cfg.skin};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius <= '0;
            r_cfg.height <= '0;
            r_cfg.skin   <= hpp_pkg::SKIN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### design/hpp_prep.sv
// First two pipeline stages: magnitudes, axial tests, sector signs and the
// doubled hexagon spans. Depends on hpp_pkg.
module hpp_prep (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  logic signed [hpp_pkg::COORD_W-1:0]   i_x,
    input  logic signed [hpp_pkg::COORD_W-1:0]   i_y,
    input  logic signed [hpp_pkg::COORD_W-1:0]   i_z,
    input  logic [hpp_pkg::MASK_W-1:0]           i_mask,
    input  hpp_pkg::t_cfg                        i_cfg,
    output logic                                 o_vld,
    output hpp_pkg::t_s2                         o_s2
);

    localparam int LW = hpp_pkg::LEN_W;

    logic         r_v1, r_v2;
    hpp_pkg::t_s1 r_s1, n_s1;
    hpp_pkg::t_s2 r_s2, n_s2;

    logic [hpp_pkg::COORD_W-1:0] az;
    logic [LW-1:0] az2, h2, k2, r2, z2, zb, zt, zb_abs, zt_abs, ay2;
    logic [LW-1:0] b_in, b_out;

    // Stage one. Everything is kept doubled so that half the skin and half
    // the height stay integral.
    always_comb begin
        az  = i_z[hpp_pkg::COORD_W-1] ? (~i_z + 1'b1) : i_z;
        az2 = {1'b0, az, 1'b0};
        h2  = LW'(i_cfg.height);
        k2  = LW'(i_cfg.skin);
        r2  = {2'b0, i_cfg.radius, 1'b0};
        z2  = {i_z[hpp_pkg::COORD_W-1], i_z, 1'b0};
        zb  = z2 + h2;
        zt  = z2 - h2;
        zb_abs = zb[LW-1] ? (~zb + 1'b1) : zb;
        zt_abs = zt[LW-1] ? (~zt + 1'b1) : zt;

        n_s1.ax = i_x[hpp_pkg::COORD_W-1] ? (~i_x + 1'b1) : i_x;
        n_s1.ay = i_y[hpp_pkg::COORD_W-1] ? (~i_y + 1'b1) : i_y;
        n_s1.a_in  = r2 - k2;
        n_s1.a_out = r2 + k2;
        n_s1.zt.in_z       = $signed(az2) < $signed(h2 - k2);
        n_s1.zt.out_z      = az2 > (h2 + k2);
        n_s1.zt.hit_bottom = zb_abs < k2;
        n_s1.zt.hit_top    = zt_abs < k2;
        n_s1.sect.x_neg  = i_x[hpp_pkg::COORD_W-1];
        n_s1.sect.x_pos  = !i_x[hpp_pkg::COORD_W-1] && (i_x != '0);
        n_s1.sect.y_neg  = i_y[hpp_pkg::COORD_W-1];
        n_s1.sect.y_pos  = !i_y[hpp_pkg::COORD_W-1] && (i_y != '0);
        n_s1.sect.origin = (i_x == '0) && (i_y == '0);
        n_s1.mask = i_mask;
    end

    // Stage two: the half-width of the hexagon at height y is a - 2|y|.
    always_comb begin
        ay2   = {1'b0, r_s1.ay, 1'b0};
        b_in  = r_s1.a_in - ay2;
        b_out = r_s1.a_out - ay2;

        n_s2.ax     = r_s1.ax;
        n_s2.ay     = r_s1.ay;
        n_s2.a_in   = r_s1.a_in[hpp_pkg::MAG_W-1:0];
        n_s2.b_in   = b_in[hpp_pkg::MAG_W-1:0];
        n_s2.a_out  = r_s1.a_out[hpp_pkg::MAG_W-1:0];
        n_s2.b_out  = b_out[hpp_pkg::MAG_W-1:0];
        n_s2.in_ok  = !r_s1.a_in[LW-1] && !b_in[LW-1];
        n_s2.out_ok = !b_out[LW-1];
        n_s2.zt     = r_s1.zt;
        n_s2.sect   = r_s1.sect;
        n_s2.mask   = r_s1.mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_vld = r_v2;
    assign o_s2  = r_s2;

endmodule

### design/hpp_square.sv
// Third pipeline stage: the six squares needed for exact comparisons.
// Depends on hpp_pkg.
module hpp_square (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  hpp_pkg::t_s2  i_s2,
    output logic          o_vld,
    output hpp_pkg::t_s3  o_s3
);

    localparam int XW = hpp_pkg::AXSQ_W;
    localparam int SW = hpp_pkg::SQ_W;

    logic         r_v3;
    hpp_pkg::t_s3 r_s3, n_s3;

    always_comb begin
        n_s3.ax_sq    = XW'(i_s2.ax) * XW'(i_s2.ax);
        n_s3.ay_sq    = XW'(i_s2.ay) * XW'(i_s2.ay);
        n_s3.a_in_sq  = SW'(i_s2.a_in) * SW'(i_s2.a_in);
        n_s3.b_in_sq  = SW'(i_s2.b_in) * SW'(i_s2.b_in);
        n_s3.a_out_sq = SW'(i_s2.a_out) * SW'(i_s2.a_out);
        n_s3.b_out_sq = SW'(i_s2.b_out) * SW'(i_s2.b_out);
        n_s3.in_ok    = i_s2.in_ok;
        n_s3.out_ok   = i_s2.out_ok;
        n_s3.zt       = i_s2.zt;
        n_s3.sect     = i_s2.sect;
        n_s3.mask     = i_s2.mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_vld = r_v3;
    assign o_s3  = r_s3;

endmodule

### design/hpp_decide.sv
// Final stage: hexagon and sector comparisons, face priority and the output
// register. Depends on hpp_pkg.
module hpp_decide (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  hpp_pkg::t_s3                 i_s3,
    output logic                         o_vld,
    output logic                         o_inside_res,
    output logic                         o_outside,
    output logic                         o_on_surface,
    output logic [hpp_pkg::FACE_W-1:0]   o_normal_face
);

    localparam int CW = hpp_pkg::CMP_W;
    localparam int SW = hpp_pkg::SQ_W;

    logic r_vld, r_inside, r_outside, r_surf;
    logic [hpp_pkg::FACE_W-1:0] r_face;

    logic [CW-1:0] x16, x4, a_in3, b_in3, a_out3, b_out3;
    logic [SW-1:0] y3;
    logic hex_in, hex_out, narrow, in_shrunk, outside, band;
    logic [hpp_pkg::NUM_FACES-1:0] hits;
    logic [hpp_pkg::FACE_W-1:0] face;
    hpp_pkg::t_sect s;

    // The apothem is sqrt(3)/2 of the circumradius; squaring both sides
    // turns that factor into the multiplications by three below.
    always_comb begin
        s      = i_s3.sect;
        x16    = {i_s3.ax_sq, 4'b0};
        x4     = {2'b0, i_s3.ax_sq, 2'b0};
        a_in3  = CW'(i_s3.a_in_sq)  + {1'b0, i_s3.a_in_sq, 1'b0};
        b_in3  = CW'(i_s3.b_in_sq)  + {1'b0, i_s3.b_in_sq, 1'b0};
        a_out3 = CW'(i_s3.a_out_sq) + {1'b0, i_s3.a_out_sq, 1'b0};
        b_out3 = CW'(i_s3.b_out_sq) + {1'b0, i_s3.b_out_sq, 1'b0};
        y3     = SW'(i_s3.ay_sq) + {1'b0, i_s3.ay_sq, 1'b0};

        hex_in  = i_s3.in_ok && (x16 <= a_in3) && (x4 <= b_in3);
        hex_out = i_s3.out_ok && (x16 <= a_out3) && (x4 <= b_out3);
        narrow  = y3 <= SW'(i_s3.ax_sq);

        in_shrunk = i_s3.zt.in_z && hex_in;
        outside   = i_s3.zt.out_z || !hex_out;
        band      = !in_shrunk && !outside;

        hits = '0;
        hits[hpp_pkg::CAP_BOTTOM] = i_s3.zt.hit_bottom;
        hits[hpp_pkg::CAP_TOP]    = i_s3.zt.hit_top;
        if (narrow) begin
            hits[hpp_pkg::SIDE_FRONT] = s.x_pos || s.origin;
            hits[hpp_pkg::SIDE_BACK]  = s.x_neg;
        end else begin
            hits[hpp_pkg::SIDE_FRONT_RIGHT] = !s.x_neg && s.y_pos;
            hits[hpp_pkg::SIDE_FRONT_LEFT]  = !s.x_neg && s.y_neg;
            hits[hpp_pkg::SIDE_BACK_RIGHT]  = !s.x_pos && s.y_pos;
            hits[hpp_pkg::SIDE_BACK_LEFT]   = !s.x_pos && s.y_neg;
        end

        // Lowest-numbered hit wins, so scan downwards.
        face = hpp_pkg::FACE_NONE;
        for (int i = hpp_pkg::NUM_FACES - 1; i >= 0; i--) begin
            if (hits[i]) begin
                face = hpp_pkg::FACE_W'(i);
            end
        end
        if (!band) begin
            face = hpp_pkg::FACE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inside  <= in_shrunk;
            r_outside <= outside;
            r_surf    <= band && ((hits & i_s3.mask) != '0);
            r_face    <= face;
        end
    end

    assign o_vld         = r_vld;
    assign o_inside_res  = r_inside;
    assign o_outside     = r_outside;
    assign o_on_surface  = r_surf;
    assign o_normal_face = r_face;

endmodule

### design/hexagonal_prism_point_classifier.sv
// Hexagonal prism point classifier: one point request can be taken every cycle
// while the pipeline is not held, and its classification passes through the four
// register stages (prepare, span, square, compare), the last being the output
// register. When the output request is not taken the whole pipeline holds, and
// a new point is still taken while the output slot is free. Radius, height and
// skin must be written through the APB port while no point is in flight; the
// block does not enforce this. All comparisons are exact.
module hexagonal_prism_point_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hpp_in_if.sink                        i_in,
    hpp_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpp_pkg::APB_AW-1:0]    paddr,
    input  logic [hpp_pkg::APB_DW-1:0]    pwdata,
    output logic [hpp_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    hpp_pkg::t_cfg cfg;
    hpp_pkg::t_s2  s2;
    hpp_pkg::t_s3  s3;
    logic en, v2, v3, vo;

    // The pipeline advances whenever the output register is empty or drained.
    assign en         = !vo || o_out.ready;
    assign i_in.ready = en;
    assign o_out.valid = vo;

    hpp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hpp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in.valid),
        .i_x     (i_in.pos_x),
        .i_y     (i_in.pos_y),
        .i_z     (i_in.pos_z),
        .i_mask  (i_in.face_mask),
        .i_cfg   (cfg),
        .o_vld   (v2),
        .o_s2    (s2)
    );

    hpp_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (v2),
        .i_s2    (s2),
        .o_vld   (v3),
        .o_s3    (s3)
    );

    hpp_decide u_decide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_vld         (v3),
        .i_s3          (s3),
        .o_vld         (vo),
        .o_inside_res  (o_out.inside_res),
        .o_outside     (o_out.outside),
        .o_on_surface  (o_out.on_surface),
        .o_normal_face (o_out.normal_face)
    );

endmodule
